// File: rtl/complex_arith_unit_macros.svh
// Assertion helpers for the top-level datapath file.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define CAU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("complex_arith_unit assertion failed");

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("complex_arith_unit assertion failed");

`endif

// File: rtl/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned AccW     = 64;
  localparam int unsigned DivSteps = 32;

  localparam logic [DataW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SatNeg = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } cau_kind_e;

  // One result part in flight: sign, too-large flag, quotient or magnitude,
  // partial remainder and the dividend bits still to shift in.
  typedef struct packed {
    logic             sgn;
    logic             big;
    logic [DataW-1:0] quo;
    logic [AccW-1:0]  rem;
    logic [DataW-1:0] low;
  } cau_lane_t;

  typedef struct packed {
    cau_kind_e       kind;
    logic            dz;
    logic [AccW-1:0] den;
    cau_lane_t       re;
    cau_lane_t       im;
  } cau_work_t;

endpackage

`default_nettype wire

// File: rtl/cau_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cau_in_if import cau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cau_kind_e               kind;
  logic signed [DataW-1:0] a_re;
  logic signed [DataW-1:0] a_im;
  logic signed [DataW-1:0] b_re;
  logic signed [DataW-1:0] b_im;

  modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if import cau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] res_re;
  logic signed [DataW-1:0] res_im;
  logic                    div_zero;
  logic                    overflow;

  modport source (output valid, res_re, res_im, div_zero, overflow, input ready);
  modport sink   (input valid, res_re, res_im, div_zero, overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/cau_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cau_front import cau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  cau_kind_e               kind_i,
  input  logic signed [DataW-1:0] a_re_i,
  input  logic signed [DataW-1:0] a_im_i,
  input  logic signed [DataW-1:0] b_re_i,
  input  logic signed [DataW-1:0] b_im_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output cau_work_t               work_o
);

  // sign-magnitude add, result {sign, magnitude}; magnitudes stay at or below 2^63
  function automatic logic [AccW:0] sm_add(logic s1, logic [AccW-1:0] m1,
                                           logic s2, logic [AccW-1:0] m2);
    logic            s;
    logic [AccW-1:0] m;
    if (s1 == s2) begin
      m = m1 + m2;
      s = s1;
    end else if (m1 >= m2) begin
      m = m1 - m2;
      s = s1;
    end else begin
      m = m2 - m1;
      s = s2;
    end
    if (m == '0) begin
      s = 1'b0;
    end
    return {s, m};
  endfunction

  function automatic logic [DataW-1:0] mag(logic signed [DataW-1:0] x);
    return x[DataW-1] ? DataW'(-x) : DataW'(x);
  endfunction

  // stage A: magnitudes, add/subtract
  logic             a_v_q;
  cau_kind_e        a_kind_q;
  logic [3:0]       a_sgn_q;
  logic [DataW-1:0] a_mag_q [4];
  cau_lane_t        a_re_q, a_im_q;
  cau_lane_t        as_re_d, as_im_d;
  logic signed [DataW:0] sum_re, sum_im;
  logic [DataW:0]   sm_re, sm_im;

  // stage B: products
  logic             b_v_q;
  cau_kind_e        b_kind_q;
  logic [3:0]       b_sgn_q;
  logic [AccW-1:0]  b_rr_q, b_ii_q, b_ri_q, b_ir_q, b_bb0_q, b_bb1_q;
  cau_lane_t        b_re_q, b_im_q;

  // stage C: combined sums
  logic             c_v_q;
  cau_kind_e        c_kind_q;
  logic [AccW:0]    c_re_q, c_im_q, c_re_d, c_im_d;
  logic [AccW-1:0]  c_den_q;
  cau_lane_t        c_are_q, c_aim_q;
  logic             s_rr, s_ii, s_ri, s_ir;

  // stage D: lane setup
  logic             d_v_q;
  cau_work_t        d_q, d_d;
  logic [AccW-1:0]  rnd_re, rnd_im;

  logic a_rdy, b_rdy, c_rdy, d_rdy;

  assign d_rdy   = !d_v_q || ready_i;
  assign c_rdy   = !c_v_q || d_rdy;
  assign b_rdy   = !b_v_q || c_rdy;
  assign a_rdy   = !a_v_q || b_rdy;
  assign ready_o = a_rdy;
  assign valid_o = d_v_q;
  assign work_o  = d_q;

  always_comb begin
    sum_re = (kind_i == KIND_ADD) ? (DataW+1)'(a_re_i) + (DataW+1)'(b_re_i)
                                  : (DataW+1)'(a_re_i) - (DataW+1)'(b_re_i);
    sum_im = (kind_i == KIND_ADD) ? (DataW+1)'(a_im_i) + (DataW+1)'(b_im_i)
                                  : (DataW+1)'(a_im_i) - (DataW+1)'(b_im_i);
    sm_re  = sum_re[DataW] ? (DataW+1)'(-sum_re) : (DataW+1)'(sum_re);
    sm_im  = sum_im[DataW] ? (DataW+1)'(-sum_im) : (DataW+1)'(sum_im);
    as_re_d     = '0;
    as_re_d.sgn = sum_re[DataW];
    as_re_d.big = sm_re[DataW];
    as_re_d.quo = sm_re[DataW-1:0];
    as_im_d     = '0;
    as_im_d.sgn = sum_im[DataW];
    as_im_d.big = sm_im[DataW];
    as_im_d.quo = sm_im[DataW-1:0];
  end

  always_comb begin
    s_rr = b_sgn_q[0] ^ b_sgn_q[2];
    s_ii = b_sgn_q[1] ^ b_sgn_q[3];
    s_ri = b_sgn_q[0] ^ b_sgn_q[3];
    s_ir = b_sgn_q[1] ^ b_sgn_q[2];
    if (b_kind_q == KIND_MUL) begin
      c_re_d = sm_add(s_rr, b_rr_q, !s_ii, b_ii_q);
      c_im_d = sm_add(s_ir, b_ir_q, s_ri, b_ri_q);
    end else begin
      c_re_d = sm_add(s_rr, b_rr_q, s_ii, b_ii_q);
      c_im_d = sm_add(s_ir, b_ir_q, !s_ri, b_ri_q);
    end
  end

  always_comb begin
    rnd_re = c_re_q[AccW-1:0] + AccW'(16'h8000);
    rnd_im = c_im_q[AccW-1:0] + AccW'(16'h8000);
    d_d      = '0;
    d_d.kind = c_kind_q;
    d_d.den  = c_den_q;
    case (c_kind_q)
      KIND_MUL: begin
        d_d.re.sgn = c_re_q[AccW];
        d_d.re.big = |rnd_re[AccW-1:48];
        d_d.re.quo = rnd_re[47:16];
        d_d.im.sgn = c_im_q[AccW];
        d_d.im.big = |rnd_im[AccW-1:48];
        d_d.im.quo = rnd_im[47:16];
      end
      KIND_DIV: begin
        d_d.dz = (c_den_q == '0);
        if (c_den_q != '0) begin
          d_d.re.sgn = c_re_q[AccW];
          d_d.re.big = {16'h0, c_re_q[AccW-1:0]} >= {c_den_q, 16'h0};
          d_d.re.rem = {16'h0, c_re_q[AccW-1:16]};
          d_d.re.low = {c_re_q[15:0], 16'h0};
          d_d.im.sgn = c_im_q[AccW];
          d_d.im.big = {16'h0, c_im_q[AccW-1:0]} >= {c_den_q, 16'h0};
          d_d.im.rem = {16'h0, c_im_q[AccW-1:16]};
          d_d.im.low = {c_im_q[15:0], 16'h0};
        end
      end
      default: begin
        d_d.re = c_are_q;
        d_d.im = c_aim_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (d_rdy) d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_kind_q   <= kind_i;
      a_sgn_q    <= {b_im_i[DataW-1], b_re_i[DataW-1], a_im_i[DataW-1], a_re_i[DataW-1]};
      a_mag_q[0] <= mag(a_re_i);
      a_mag_q[1] <= mag(a_im_i);
      a_mag_q[2] <= mag(b_re_i);
      a_mag_q[3] <= mag(b_im_i);
      a_re_q     <= as_re_d;
      a_im_q     <= as_im_d;
    end
    if (b_rdy) begin
      b_kind_q <= a_kind_q;
      b_sgn_q  <= a_sgn_q;
      b_rr_q   <= a_mag_q[0] * a_mag_q[2];
      b_ii_q   <= a_mag_q[1] * a_mag_q[3];
      b_ri_q   <= a_mag_q[0] * a_mag_q[3];
      b_ir_q   <= a_mag_q[1] * a_mag_q[2];
      b_bb0_q  <= a_mag_q[2] * a_mag_q[2];
      b_bb1_q  <= a_mag_q[3] * a_mag_q[3];
      b_re_q   <= a_re_q;
      b_im_q   <= a_im_q;
    end
    if (c_rdy) begin
      c_kind_q <= b_kind_q;
      c_re_q   <= c_re_d;
      c_im_q   <= c_im_d;
      c_den_q  <= b_bb0_q + b_bb1_q;
      c_are_q  <= b_re_q;
      c_aim_q  <= b_im_q;
    end
    if (d_rdy) begin
      d_q <= d_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cau_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

module cau_div_step import cau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cau_work_t work_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cau_work_t work_o
);

  // one restoring step: shift in a dividend bit, subtract when it fits
  function automatic cau_lane_t step(cau_lane_t l, logic [AccW-1:0] den);
    cau_lane_t       r;
    logic [AccW-1:0] sh;
    logic            ge;
    r     = l;
    sh    = {l.rem[AccW-2:0], l.low[DataW-1]};
    ge    = (sh >= den);
    r.rem = ge ? sh - den : sh;
    r.quo = {l.quo[DataW-2:0], ge};
    r.low = {l.low[DataW-2:0], 1'b0};
    return r;
  endfunction

  logic      v_q;
  cau_work_t w_q, w_d;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign work_o  = w_q;

  always_comb begin
    w_d = work_i;
    if (work_i.kind == KIND_DIV && !work_i.dz) begin
      w_d.re = step(work_i.re, work_i.den);
      w_d.im = step(work_i.im, work_i.den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      w_q <= w_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cau_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cau_back import cau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  cau_work_t               work_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [DataW-1:0] res_re_o,
  output logic signed [DataW-1:0] res_im_o,
  output logic                    div_zero_o,
  output logic                    overflow_o
);

  // round the quotient half away from zero, then clamp; returns {ovf, value}
  function automatic logic [DataW:0] finish(cau_lane_t l, logic rnd_en,
                                            logic [AccW-1:0] den);
    logic           rnd;
    logic [DataW:0] m;
    logic           ovf;
    logic [DataW-1:0] v;
    rnd = rnd_en && ({l.rem, 1'b0} >= {1'b0, den});
    m   = {1'b0, l.quo} + (DataW+1)'(rnd);
    if (!l.sgn) begin
      ovf = l.big || (m > {1'b0, SatPos});
      v   = ovf ? SatPos : m[DataW-1:0];
    end else begin
      ovf = l.big || (m > {1'b0, SatNeg});
      v   = ovf ? SatNeg : DataW'(-m[DataW-1:0]);
    end
    return {ovf, v};
  endfunction

  logic           v_q;
  logic           rnd_en;
  logic [DataW:0] f_re, f_im;
  logic signed [DataW-1:0] re_q, im_q;
  logic           dz_q, ovf_q;

  assign ready_o    = !v_q || ready_i;
  assign valid_o    = v_q;
  assign res_re_o   = re_q;
  assign res_im_o   = im_q;
  assign div_zero_o = dz_q;
  assign overflow_o = ovf_q;

  assign rnd_en = (work_i.kind == KIND_DIV) && !work_i.dz;
  assign f_re   = finish(work_i.re, rnd_en, work_i.den);
  assign f_im   = finish(work_i.im, rnd_en, work_i.den);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      re_q  <= f_re[DataW-1:0];
      im_q  <= f_im[DataW-1:0];
      dz_q  <= work_i.dz;
      ovf_q <= f_re[DataW] | f_im[DataW];
    end
  end

endmodule

`default_nettype wire

// File: rtl/complex_arith_unit.sv
// All kinds take the same path: front end, divider steps, output register, out_o.
// Throughput: one item per cycle while out_o takes results; the 32-step restoring divider is fully pipelined.
// Every stage holds its own valid bit, so bubbles close up while out_o stalls.
// Reset (rst_ni low, asynchronous) clears the valid bits only; no state is kept.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arith_unit_macros.svh"

module complex_arith_unit import cau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);

  // Front end: magnitudes, six products, sign-magnitude sums, lane setup.
  logic      v_s   [DivSteps+1];
  logic      r_s   [DivSteps+1];
  cau_work_t w_s   [DivSteps+1];

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .kind_i  (in_i.kind),
    .a_re_i  (in_i.a_re),
    .a_im_i  (in_i.a_im),
    .b_re_i  (in_i.b_re),
    .b_im_i  (in_i.b_im),
    .valid_o (v_s[0]),
    .ready_i (r_s[0]),
    .work_o  (w_s[0])
  );

  // Divider: one quotient bit per stage for both parts; other kinds pass through.
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    cau_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_s[g]),
      .ready_o (r_s[g]),
      .work_i  (w_s[g]),
      .valid_o (v_s[g+1]),
      .ready_i (r_s[g+1]),
      .work_o  (w_s[g+1])
    );
  end

  // Output register: round, saturate, flag.
  cau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v_s[DivSteps]),
    .ready_o    (r_s[DivSteps]),
    .work_i     (w_s[DivSteps]),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .res_re_o   (out_o.res_re),
    .res_im_o   (out_o.res_im),
    .div_zero_o (out_o.div_zero),
    .overflow_o (out_o.overflow)
  );

  // A zero divisor yields a clean zero result with no saturation.
  `CAU_ASSERT_IMPL(a_dz_zero, out_o.valid && out_o.div_zero,
                   out_o.res_re == '0 && out_o.res_im == '0 && !out_o.overflow)
  // Overflow means at least one part sits on a clamp bound.
  `CAU_ASSERT_IMPL(a_ovf_bound, out_o.valid && out_o.overflow,
                   out_o.res_re == SatPos || out_o.res_re == SatNeg ||
                   out_o.res_im == SatPos || out_o.res_im == SatNeg)
  // Lanes reaching the back end without a divide never carry a zero-divisor flag.
  `CAU_ASSERT_IMPL(a_dz_kind, v_s[DivSteps] && w_s[DivSteps].kind != KIND_DIV,
                   !w_s[DivSteps].dz)
  // A full output stage that is not taken stays full.
  `CAU_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid)

endmodule

`default_nettype wire

// File: verif/cau_tb_if.sv
`timescale 1ns / 1ps

// Result type for the checker; the channel interfaces come from the RTL (cau_in_if, cau_out_if).
// It follows cau_pkg in build order, since cplx_result_t uses DataW.
package cau_tb_types;
  import cau_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] re;
    logic [DataW-1:0] im;
    logic             dz;
    logic             ovf;
  } cplx_result_t;
endpackage

// File: verif/complex_arith_checker.sv
`timescale 1ns / 1ps

module complex_arith_checker
  import cau_pkg::*;
  import cau_tb_types::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cau_in_if           in_ch,
  cau_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  cplx_result_t expected_results[$];

  // Saturate a signed value held in 128 bits to a 32-bit pattern.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sh7FFF_FFFF) begin
      ovf = 1'b1;
      return SatPos;
    end
    if (v < -128'sh8000_0000) begin
      ovf = 1'b1;
      return SatNeg;
    end
    return v[31:0];
  endfunction

  // round(n * 2^16 / den), ties away from zero, magnitude capped at 2^40.
  function automatic logic signed [127:0] div_q16(input logic signed [127:0] n,
                                                  input logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] r;
    mag = (n < 0) ? -n : n;
    q = (mag << 16) / den;
    r = (mag << 16) % den;
    if (q > (128'd1 << 40)) begin
      q = 128'd1 << 40;
    end else if (r >= den - r) begin
      q = q + 1;
    end
    return (n < 0) ? -$signed(q) : $signed(q);
  endfunction

  // Q32.32 to Q16.16, to nearest with ties away from zero.
  function automatic logic signed [127:0] round_q16(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = (m + 128'sh8000) >>> 16;
    return (v < 0) ? -m : m;
  endfunction

  function automatic cplx_result_t predict_cplx(input cau_kind_e k,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    cplx_result_t r;
    logic signed [127:0] xr, xi, er, ei;
    logic [127:0] den;
    logic ovf;
    ovf = 1'b0;
    r = '0;
    xr = ar; xi = ai; er = br; ei = bi;
    case (k)
      KIND_ADD: begin
        r.re = clamp32(xr + er, ovf);
        r.im = clamp32(xi + ei, ovf);
      end
      KIND_SUB: begin
        r.re = clamp32(xr - er, ovf);
        r.im = clamp32(xi - ei, ovf);
      end
      KIND_MUL: begin
        r.re = clamp32(round_q16(xr * er - xi * ei), ovf);
        r.im = clamp32(round_q16(xr * ei + xi * er), ovf);
      end
      default: begin
        den = $unsigned(er * er + ei * ei);
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = clamp32(div_q16(xr * er + xi * ei, den), ovf);
          r.im = clamp32(div_q16(xi * er - xr * ei, den), ovf);
        end
      end
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cplx_result_t want;
    if (!rst_ni) begin
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_cplx(in_ch.kind, in_ch.a_re, in_ch.a_im,
                                                in_ch.b_re, in_ch.b_im));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", 32'd0, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.res_re !== want.re) report_mismatch("res_re", out_ch.res_re, want.re);
          if (out_ch.res_im !== want.im) report_mismatch("res_im", out_ch.res_im, want.im);
          if (out_ch.div_zero !== want.dz)
            report_mismatch("div_zero", out_ch.div_zero, want.dz);
          if (out_ch.overflow !== want.ovf)
            report_mismatch("overflow", out_ch.overflow, want.ovf);
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// File: verif/complex_arith_unit_test.sv
`timescale 1ns / 1ps

module complex_arith_unit_test;
  import cau_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned Latency    = 36;

  logic clk_i;
  logic rst_ni;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned idle_cycles;
  int unsigned drain_cycles;
  bit          hold_off;

  cau_in_if  in_ch ();
  cau_out_if out_ch ();

  complex_arith_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  complex_arith_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Pick an operand part: mostly random, often an extreme or a small value.
  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return $signed($urandom_range(0, 16'hFFFF)) - 32'sd32768;
      5: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // Offer one item and hold it until the block takes it; valid drops only while idling.
  task automatic send_item(input cau_kind_e k, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.a_re  <= ar;
    in_ch.a_im  <= ai;
    in_ch.b_re  <= br;
    in_ch.b_im  <= bi;
    // Wait for the accepting edge, then step to the falling edge.
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_item(cau_kind_e'($urandom_range(0, 3)), pick_part(), pick_part(),
                pick_part(), pick_part());
    end
  endtask

  // Receiver: drop ready at random, and hold off for long when asked.
  always @(negedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: count edges with no accepted item.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Long hold-off while the sender keeps offering items.
  initial begin
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (400) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (150) @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_ADD;
    in_ch.a_re    = '0;
    in_ch.a_im    = '0;
    in_ch.b_re    = '0;
    in_ch.b_im    = '0;
    out_ch.ready  = 1'b0;
    idle_cycles   = 0;
    send_idle_pct = 11;
    recv_idle_pct = 47;
    rst_ni        = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, each operation, saturation, divide by zero.
    send_item(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(KIND_ADD, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_8000, 32'h0000_0000);
    send_item(KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(KIND_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000);
    send_item(KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
    send_item(KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
    send_item(KIND_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_7FFF, 32'h0000_0000);
    send_item(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_DIV, 32'h0006_0000, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(KIND_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000);
    send_item(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(KIND_DIV, 32'h0000_0001, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
    send_item(KIND_DIV, 32'h0000_0001, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000);
    send_item(KIND_DIV, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_DIV, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

    // Random in three idling phases.
    send_random(580);
    send_idle_pct = 47;
    recv_idle_pct = 11;
    send_random(580);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(580);
    in_ch.valid <= 1'b0;

    // Drain, then allow the pipeline depth for stray results.
    drain_cycles = 0;
    while (pending_count != 0 && drain_cycles < StallLimit) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (Latency + 10) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/cau_back.sv
rtl/complex_arith_unit.sv
verif/cau_tb_if.sv
verif/complex_arith_checker.sv
verif/complex_arith_unit_test.sv
